@@ sv/lkvc_pkg.sv @@
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // per-cell update selection
    localparam logic [2:0] MODE_HOLD = 3'd0;
    localparam logic [2:0] MODE_MOVE = 3'd1;
    localparam logic [2:0] MODE_MOVE_EVICT = 3'd2;
    localparam logic [2:0] MODE_APPEND = 3'd3;
    localparam logic [2:0] MODE_SHIFT_IN = 3'd4;

    typedef struct packed {
        logic op;
        logic signed [KEY_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic hit;
        logic signed [DATA_W-1:0] read_value;
        logic evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } resp_t;

    typedef struct packed {
        logic apply;
        logic [2:0] mode;
    } cell_ctrl_t;

endpackage

@@ sv/lru_key_value_cache.sv @@
// Fully associative key/value cache with LRU replacement, built as a row of cells kept in
// recency order (cell 0 least recent). In the cycle a transaction is accepted every cell
// compares its key and registers the match; once the output register is free the row shifts to
// its new order and the result is loaded into the output register, and only then is a new
// transaction accepted. A put of a new key while the entry count has reached the effective
// capacity, or a put of a present key while the count is above it, evicts the least recent
// entry other than the put key and reports its key. Writes to the capacity register belong
// between transactions; 0 acts as 1 and values above ENTRIES act as ENTRIES.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output resp_t            out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              busy_reg;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              out_valid_reg;
    resp_t             out_reg;
    resp_t             out_next;

    logic              accept;
    logic              apply;
    cell_ctrl_t        ctrl;
    logic [CMP_W-1:0]  cap_w;
    logic [CMP_W-1:0]  cap_eff;
    logic [CMP_W-1:0]  used_w;
    logic              over_cap;
    logic              at_cap;
    logic              hit;
    logic [DATA_W-1:0] hit_data;
    logic [DATA_W-1:0] new_data;

    logic [KEY_W-1:0]  cell_key [ENTRIES+2];
    logic [DATA_W-1:0] cell_data [ENTRIES+2];
    logic              seen [ENTRIES+2];
    logic [ENTRIES-1:0] match;

    assign in_ready = !busy_reg;
    assign cfg_ready = 1'b1;
    assign accept = in_valid && in_ready;
    assign apply = busy_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    assign cell_key[ENTRIES] = '0;
    assign cell_key[ENTRIES+1] = '0;
    assign cell_data[ENTRIES] = '0;
    assign cell_data[ENTRIES+1] = '0;
    assign seen[0] = 1'b0;
    assign seen[ENTRIES+1] = 1'b1;

    generate
        for (genvar i = 0; i < ENTRIES; i++)
        begin : g_cell
            lkvc_cell #(
                .ENTRIES(ENTRIES),
                .IDX(i)
            ) u_cell (
                .clk(clk),
                .ctrl(ctrl),
                .count(count_reg),
                .cmp_en(accept),
                .lookup_key(in_data.key),
                .seen_in(seen[i]),
                .seen_next(seen[i+2]),
                .seen_out(seen[i+1]),
                .match(match[i]),
                .nxt1_key(cell_key[i+1]),
                .nxt1_data(cell_data[i+1]),
                .nxt2_key(cell_key[i+2]),
                .nxt2_data(cell_data[i+2]),
                .new_key(key_reg),
                .new_data(new_data),
                .key(cell_key[i]),
                .data(cell_data[i])
            );
        end
    endgenerate

    assign hit = seen[ENTRIES];

    always_comb
    begin
        hit_data = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_data = hit_data | (match[i] ? cell_data[i] : '0);
        end
    end

    assign cap_w = CMP_W'(cap_reg);
    assign used_w = CMP_W'(count_reg);

    always_comb
    begin
        if (cap_w == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_w > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_w;
        end
    end

    assign over_cap = used_w > cap_eff;
    assign at_cap = used_w >= cap_eff;
    assign new_data = (op_reg == OP_PUT) ? value_reg : hit_data;

    always_comb
    begin
        ctrl.apply = apply;
        ctrl.mode = MODE_HOLD;
        count_next = count_reg;
        out_next.hit = hit;
        out_next.read_value = '0;
        out_next.evicted = 1'b0;
        out_next.evicted_key = '0;
        if (op_reg == OP_GET)
        begin
            out_next.read_value = hit ? hit_data : MISS_VALUE;
            if (hit)
            begin
                ctrl.mode = MODE_MOVE;
            end
        end
        else if (hit)
        begin
            if (over_cap)
            begin
                ctrl.mode = MODE_MOVE_EVICT;
                count_next = count_reg - CNT_W'(1);
                out_next.evicted = 1'b1;
                out_next.evicted_key = match[0] ? cell_key[1] : cell_key[0];
            end
            else
            begin
                ctrl.mode = MODE_MOVE;
            end
        end
        else if (at_cap)
        begin
            ctrl.mode = MODE_SHIFT_IN;
            out_next.evicted = 1'b1;
            out_next.evicted_key = cell_key[0];
        end
        else
        begin
            ctrl.mode = MODE_APPEND;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            count_reg <= '0;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (apply)
            begin
                busy_reg <= 1'b0;
            end
            if (apply)
            begin
                count_reg <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_data.op;
            key_reg <= in_data.key;
            value_reg <= in_data.value;
        end
        if (apply)
        begin
            out_reg <= out_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above number of cells");

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(match))
        else $error("key matched in more than one cell");

    a_evict_put: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.evicted) |-> (out_data.read_value == '0))
        else $error("eviction reported on a get");

    a_apply_done: assert property (@(posedge clk) disable iff (!rst_n)
        apply |=> (!busy_reg && out_valid_reg))
        else $error("transaction not retired after update");

endmodule

@@ sv/lkvc_cell.sv @@
module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IDX = 0
)
(
    input  logic                         clk,
    input  cell_ctrl_t                   ctrl,
    input  logic [$clog2(ENTRIES+1)-1:0] count,
    input  logic                         cmp_en,
    input  logic [KEY_W-1:0]             lookup_key,
    input  logic                         seen_in,
    input  logic                         seen_next,
    output logic                         seen_out,
    output logic                         match,
    input  logic [KEY_W-1:0]             nxt1_key,
    input  logic [DATA_W-1:0]            nxt1_data,
    input  logic [KEY_W-1:0]             nxt2_key,
    input  logic [DATA_W-1:0]            nxt2_data,
    input  logic [KEY_W-1:0]             new_key,
    input  logic [DATA_W-1:0]            new_data,
    output logic [KEY_W-1:0]             key,
    output logic [DATA_W-1:0]            data
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW1 = CNT_W + 1;
    localparam logic [CW1-1:0] I0 = CW1'(IDX);
    localparam logic [CW1-1:0] I1 = CW1'(IDX + 1);
    localparam logic [CW1-1:0] I2 = CW1'(IDX + 2);
    localparam logic [CW1-1:0] I3 = CW1'(IDX + 3);

    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              match_reg;
    logic              match_next;
    logic [CW1-1:0]    used;

    assign used = {1'b0, count};
    assign match_next = (used > I0) && (key_reg == lookup_key);
    assign seen_out = seen_in | match_reg;
    assign match = match_reg;
    assign key = key_reg;
    assign data = data_reg;

    always_comb
    begin
        key_next = key_reg;
        data_next = data_reg;
        case (ctrl.mode)
            MODE_MOVE:
            begin
                if (seen_out && (used > I1))
                begin
                    key_next = nxt1_key;
                    data_next = nxt1_data;
                end
                else if (used == I1)
                begin
                    key_next = new_key;
                    data_next = new_data;
                end
            end
            MODE_MOVE_EVICT:
            begin
                if (!seen_next)
                begin
                    key_next = nxt1_key;
                    data_next = nxt1_data;
                end
                else if (used >= I3)
                begin
                    key_next = nxt2_key;
                    data_next = nxt2_data;
                end
                else if (used == I2)
                begin
                    key_next = new_key;
                    data_next = new_data;
                end
            end
            MODE_APPEND:
            begin
                if (used == I0)
                begin
                    key_next = new_key;
                    data_next = new_data;
                end
            end
            MODE_SHIFT_IN:
            begin
                if (used >= I2)
                begin
                    key_next = nxt1_key;
                    data_next = nxt1_data;
                end
                else if (used == I1)
                begin
                    key_next = new_key;
                    data_next = new_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            match_reg <= match_next;
        end
        if (ctrl.apply)
        begin
            key_reg <= key_next;
            data_reg <= data_next;
        end
    end

endmodule
